// ===== hdl/brg_pkg.sv =====
// ----------------------------------------------------------------------------
// brg_pkg: shared constants of the bounded random generator
// Word widths and the splitmix64 constants used by the sequencer and its
// arithmetic units.
// ----------------------------------------------------------------------------
package brg_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int DVD_W  = HALF_W + 1;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  localparam int SHIFT_1 = 30;
  localparam int SHIFT_2 = 27;
  localparam int SHIFT_3 = 31;

  // 2^32 as a 33-bit dividend, for the rejection limit
  localparam logic [DVD_W-1:0] TWO_POW_HALF = {1'b1, {HALF_W{1'b0}}};

endpackage

// ===== hdl/bounded_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// bounded_random_generator_top: splitmix64 generator with bounded draws
// Each request returns a raw 64-bit draw (action 0) or a uniform value below
// bound (action 1), using rejection sampling on the low 32 bits.
// ----------------------------------------------------------------------------
// Use:
//   Request channel: in_valid / in_stall with action and bound. A request is
//   taken only while the sequencer is idle; in_stall is high otherwise.
//   Result channel: out_valid / out_stall with value, held in an output
//   register, so the next request may be taken while a result waits.
//   Seed channel: cfg_valid / cfg_ready with seed; a transfer loads the
//   generator state. cfg_ready is high only while the sequencer is idle.
// Sequence:
//   A raw draw runs the state add, two 64-bit multiplies on the shared
//   32 x 32 multiplier, the xor-shifts and the output register.
//   A bounded draw first runs the remainder unit for the rejection limit,
//   and after an accepted draw runs it again for the final modulo; a
//   rejected draw repeats from the state add.
//   A bound below two returns 0. The next request may be taken in the same
//   cycle that the result appears in the output register.
// Reset clears the generator state to zero and empties the output register.
// While the receiver stalls, a finished result waits in the sequencer until
// the output register is free.
// ----------------------------------------------------------------------------
module bounded_random_generator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brg_pkg::WORD_W-1:0] seed,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [brg_pkg::HALF_W-1:0] bound,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brg_pkg::WORD_W-1:0] value
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIMIT = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                 fsm;
  logic [brg_pkg::WORD_W-1:0] gen_state;
  logic                       action_q;
  logic [brg_pkg::HALF_W-1:0] bound_q;
  logic [brg_pkg::HALF_W-1:0] gap;
  logic [brg_pkg::WORD_W-1:0] result;

  logic                       in_take;
  logic                       out_free;
  logic [brg_pkg::WORD_W-1:0] state_next;
  logic [brg_pkg::WORD_W-1:0] mix0;
  logic [brg_pkg::WORD_W-1:0] mix1;
  logic [brg_pkg::WORD_W-1:0] draw;
  logic [brg_pkg::HALF_W:0]   accept_sum;

  logic                       mul_start;
  logic [brg_pkg::WORD_W-1:0] mul_a;
  logic [brg_pkg::WORD_W-1:0] mul_b;
  logic                       mul_done;
  logic [brg_pkg::WORD_W-1:0] mul_prod;

  logic                       div_start;
  logic [brg_pkg::DVD_W-1:0]  div_dvd;
  logic [brg_pkg::HALF_W-1:0] div_dsr;
  logic                       div_done;
  logic [brg_pkg::HALF_W-1:0] div_rem;

  brg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  brg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  // handshakes
  assign in_stall  = (fsm != S_IDLE);
  assign cfg_ready = (fsm == S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // mixing steps around the multiplies
  assign state_next = gen_state + brg_pkg::GOLDEN_STEP;
  assign mix0 = state_next ^ (state_next >> brg_pkg::SHIFT_1);
  assign mix1 = mul_prod ^ (mul_prod >> brg_pkg::SHIFT_2);
  assign draw = mul_prod ^ (mul_prod >> brg_pkg::SHIFT_3);

  // accept when v < 2^32 - (2^32 mod bound), i.e. v + gap has no carry out
  assign accept_sum = {1'b0, draw[brg_pkg::HALF_W-1:0]} + {1'b0, gap};

  // unit requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = mix0;
    mul_b     = brg_pkg::MIX_MUL_A;
    div_start = 1'b0;
    div_dvd   = brg_pkg::TWO_POW_HALF;
    div_dsr   = bound;
    case (fsm)
      S_IDLE: begin
        div_start = in_take && action && (bound > 32'd1);
      end
      S_ADV: begin
        mul_start = 1'b1;
      end
      S_MUL1: begin
        mul_start = mul_done;
        mul_a     = mix1;
        mul_b     = brg_pkg::MIX_MUL_B;
      end
      S_MUL2: begin
        div_start = mul_done && action_q && !accept_sum[brg_pkg::HALF_W];
        div_dvd   = {1'b0, draw[brg_pkg::HALF_W-1:0]};
        div_dsr   = bound_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      gen_state <= '0;
      out_valid <= 1'b0;
    end else begin
      // raise the result into a free output register, drop it once taken
      if (fsm == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (cfg_valid) begin
            gen_state <= seed;
          end
          if (in_take) begin
            if (!action) begin
              fsm <= S_ADV;
            end else if (bound > 32'd1) begin
              fsm <= S_LIMIT;
            end else begin
              fsm <= S_DONE;
            end
          end
        end
        S_LIMIT: begin
          if (div_done) begin
            fsm <= S_ADV;
          end
        end
        S_ADV: begin
          gen_state <= state_next;
          fsm       <= S_MUL1;
        end
        S_MUL1: begin
          if (mul_done) begin
            fsm <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_done) begin
            if (!action_q) begin
              fsm <= S_DONE;
            end else if (!accept_sum[brg_pkg::HALF_W]) begin
              fsm <= S_MOD;
            end else begin
              fsm <= S_ADV;
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            fsm <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // request fields, limit gap, result and output register
  always_ff @(posedge clk) begin
    if (in_take) begin
      action_q <= action;
      bound_q  <= bound;
      result   <= '0;
    end
    if (fsm == S_LIMIT && div_done) begin
      gap <= div_rem;
    end
    if (fsm == S_MUL2 && mul_done && !action_q) begin
      result <= draw;
    end
    if (fsm == S_MOD && div_done) begin
      result <= {{brg_pkg::HALF_W{1'b0}}, div_rem};
    end
    if (fsm == S_DONE && out_free) begin
      value <= result;
    end
  end

  // checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and remainder unit finished together");

  a_mul_done_phase: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (fsm == S_MUL1 || fsm == S_MUL2))
    else $error("multiplier finished outside a multiply step");

  a_div_done_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (fsm == S_LIMIT || fsm == S_MOD))
    else $error("remainder unit finished outside a divide step");

  a_mod_below_bound: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_MOD && div_done) |-> (div_rem < bound_q))
    else $error("bounded result not below bound");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (fsm != S_IDLE))
    else $error("sequencer stayed idle after taking a request");

endmodule

// ===== hdl/brg_mul.sv =====
// ----------------------------------------------------------------------------
// brg_mul: iterative 64 x 64 multiplier, low 64 bits of the product
// One 32 x 32 multiplier is reused in turn: low x low, then the
// two cross products, whose low halves are added into the upper word.
// ----------------------------------------------------------------------------
module brg_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [brg_pkg::WORD_W-1:0] a,
  input  logic [brg_pkg::WORD_W-1:0] b,
  output logic                      done,
  output logic [brg_pkg::WORD_W-1:0] prod
);

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;

  logic [brg_pkg::WORD_W-1:0] a_op;
  logic [brg_pkg::WORD_W-1:0] b_op;
  logic [brg_pkg::WORD_W-1:0] acc;
  logic                       busy;
  logic [1:0]                 phase;
  logic [brg_pkg::HALF_W-1:0] mul_a;
  logic [brg_pkg::HALF_W-1:0] mul_b;
  logic [brg_pkg::WORD_W-1:0] part;

  // pick the half-words for this phase
  always_comb begin
    case (phase)
      PH_LL: begin
        mul_a = a_op[brg_pkg::HALF_W-1:0];
        mul_b = b_op[brg_pkg::HALF_W-1:0];
      end
      PH_LH: begin
        mul_a = a_op[brg_pkg::HALF_W-1:0];
        mul_b = b_op[brg_pkg::WORD_W-1:brg_pkg::HALF_W];
      end
      PH_HL: begin
        mul_a = a_op[brg_pkg::WORD_W-1:brg_pkg::HALF_W];
        mul_b = b_op[brg_pkg::HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign part = {{brg_pkg::HALF_W{1'b0}}, mul_a} * {{brg_pkg::HALF_W{1'b0}}, mul_b};

  // control: load on start, advance through the three phases
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_LL;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= PH_LL;
      end else if (busy) begin
        if (phase == PH_HL) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_op <= a;
      b_op <= b;
    end
    if (busy && !start) begin
      if (phase == PH_LL) begin
        acc <= part;
      end else begin
        acc[brg_pkg::WORD_W-1:brg_pkg::HALF_W] <=
          acc[brg_pkg::WORD_W-1:brg_pkg::HALF_W] + part[brg_pkg::HALF_W-1:0];
      end
    end
  end

  assign prod = acc;

endmodule

// ===== hdl/brg_div.sv =====
// ----------------------------------------------------------------------------
// brg_div: restoring shift-subtract remainder unit
// Takes a 33-bit dividend and a 32-bit divisor and produces the remainder,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module brg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [brg_pkg::DVD_W-1:0]  dividend,
  input  logic [brg_pkg::HALF_W-1:0] divisor,
  output logic                       done,
  output logic [brg_pkg::HALF_W-1:0] rem
);

  localparam int STEPS = brg_pkg::DVD_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [brg_pkg::DVD_W-1:0]  dvd;
  logic [brg_pkg::HALF_W-1:0] dsr;
  logic [brg_pkg::HALF_W-1:0] part_rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [brg_pkg::DVD_W-1:0]  shifted;
  logic [brg_pkg::DVD_W-1:0]  diff;
  logic [brg_pkg::HALF_W-1:0] rem_next;

  // one trial subtraction per cycle
  assign shifted = {part_rem, dvd[brg_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign rem_next = (shifted >= {1'b0, dsr}) ? diff[brg_pkg::HALF_W-1:0]
                                             : shifted[brg_pkg::HALF_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dsr      <= divisor;
      part_rem <= '0;
    end else if (busy) begin
      dvd      <= {dvd[brg_pkg::DVD_W-2:0], 1'b0};
      part_rem <= rem_next;
    end
  end

  assign rem = part_rem;

endmodule

// ===== dv/brg_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brg_tb_pkg: request codes shared by the generator testbench
// Names the two request kinds that the stimulus and the checker agree on.
// ----------------------------------------------------------------------------
package brg_tb_pkg;

  typedef enum logic {
    ACT_RAW     = 1'b0,
    ACT_BOUNDED = 1'b1
  } draw_kind_e;

endpackage

// ===== dv/brg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brg_checker: result predictor and scoreboard for the bounded generator
// Follows seed loads and accepted requests with its own splitmix64 state,
// queues the expected value of each request and compares every result
// transfer against the oldest entry.
// ----------------------------------------------------------------------------
module brg_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [brg_pkg::WORD_W-1:0] seed,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       action,
  input  logic [brg_pkg::HALF_W-1:0] bound,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [brg_pkg::WORD_W-1:0] value,
  output int                         fail_count,
  output int                         pending,
  output int                         compared
);

  localparam logic [63:0] STEP_INC  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_FIRST = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL_LAST  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SPAN_32   = 64'h1_0000_0000;
  localparam logic [63:0] LOW_MASK  = 64'hFFFF_FFFF;

  logic [63:0] mix_state;
  logic [63:0] expected_values[$];

  // Advance the state and mix it into one 64-bit draw
  function automatic logic [63:0] next_mix();
    logic [63:0] z;
    mix_state = mix_state + STEP_INC;
    z = mix_state;
    z = (z ^ (z >> 30)) * MUL_FIRST;
    z = (z ^ (z >> 27)) * MUL_LAST;
    return z ^ (z >> 31);
  endfunction

  // Reject low words at or above the largest multiple of the bound
  function automatic logic [63:0] draw_below_bound(input logic [31:0] lim);
    logic [63:0] wide_lim;
    logic [63:0] accept_top;
    logic [63:0] low_word;
    wide_lim = {32'b0, lim};
    if (wide_lim < 64'd2) begin
      return 64'd0;
    end
    accept_top = (SPAN_32 / wide_lim) * wide_lim;
    do begin
      low_word = next_mix() & LOW_MASK;
    end while (low_word >= accept_top);
    return low_word % wide_lim;
  endfunction

  // Track seed loads, predict each request and check each result
  always @(posedge clk) begin
    if (rst) begin
      mix_state  = 64'd0;
      fail_count = 0;
      compared   = 0;
      expected_values.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mix_state = seed;
      end
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          $error("value transfer with nothing expected: actual %h", value);
          fail_count = fail_count + 1;
        end else begin
          if (value !== expected_values[0]) begin
            $error("value mismatch: expected %h, actual %h", expected_values[0], value);
            fail_count = fail_count + 1;
          end
          void'(expected_values.pop_front());
          compared = compared + 1;
        end
      end
      if (in_valid && !in_stall) begin
        if (action == brg_tb_pkg::ACT_BOUNDED) begin
          expected_values = {expected_values, draw_below_bound(bound)};
        end else begin
          expected_values = {expected_values, next_mix()};
        end
      end
    end
    pending = expected_values.size();
  end

endmodule

// ===== dv/tb_bounded_random_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_random_generator_top: testbench for the bounded generator
// Loads several seeds, sends directed and random raw and bounded requests
// under four handshake pressure phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_bounded_random_generator_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int ITEMS_PER_PHASE = 138;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] seed      = 64'd0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        action    = 1'b0;
  logic [31:0] bound     = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value;

  int fail_count;
  int pending;
  int compared;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int raw_sent       = 0;
  int bounded_sent   = 0;
  int tiny_sent      = 0;
  int seeds_loaded   = 0;
  int idle_cycles    = 0;

  bounded_random_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .bound     (bound),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
  );

  brg_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .seed       (seed),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .bound      (bound),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at the rate of the current phase
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request after an optional idle gap; call and return at a falling edge
  task automatic send_req(input brg_tb_pkg::draw_kind_e kind, input logic [31:0] lim);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      action   <= 1'($urandom_range(1));
      bound    <= $urandom();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= kind;
    bound    <= lim;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (kind == brg_tb_pkg::ACT_RAW) begin
      raw_sent++;
    end else begin
      bounded_sent++;
      if (lim < 32'd2) tiny_sent++;
    end
  endtask

  // Drain all results, then load a new seed while the block is idle
  task automatic load_seed(input logic [63:0] s);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    seed      <= s;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    seeds_loaded++;
  endtask

  initial begin
    int          pick;
    int          send_pct[4];
    int          recv_pct[4];
    logic [63:0] phase_seed[4];

    send_pct      = '{0, 81, 0, 34};
    recv_pct      = '{0, 0, 81, 34};
    phase_seed[0] = 64'd0;
    phase_seed[1] = {64{1'b1}};
    phase_seed[2] = 64'h8000_0000_0000_0000;
    phase_seed[3] = {$urandom(), $urandom()};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests from the reset state
    send_req(brg_tb_pkg::ACT_RAW, 32'd0);
    send_req(brg_tb_pkg::ACT_RAW, 32'hFFFF_FFFF);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd0);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd1);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd2);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd3);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd10);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'hFFFF_FFFF);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'hFFFF_FFFE);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h8000_0000);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h8000_0001);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h8000_0001);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h8000_0001);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h7FFF_FFFF);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h0001_0000);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'h5555_5555);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'hAAAA_AAAA);
    send_req(brg_tb_pkg::ACT_RAW, 32'hAAAA_AAAA);
    send_req(brg_tb_pkg::ACT_BOUNDED, 32'd1);
    send_req(brg_tb_pkg::ACT_RAW, 32'd1);

    // Random requests, one seed and one pressure setting per phase
    for (int p = 0; p < 4; p++) begin
      load_seed(phase_seed[p]);
      send_idle_pct   = send_pct[p];
      recv_stall_pct <= recv_pct[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          send_req(brg_tb_pkg::ACT_RAW, $urandom());
        end else if (pick < 37) begin
          send_req(brg_tb_pkg::ACT_BOUNDED, $urandom_range(1));
        end else if (pick < 57) begin
          send_req(brg_tb_pkg::ACT_BOUNDED, $urandom_range(16, 2));
        end else if (pick < 80) begin
          send_req(brg_tb_pkg::ACT_BOUNDED, $urandom());
        end else if (pick < 90) begin
          send_req(brg_tb_pkg::ACT_BOUNDED, 32'h8000_0000 + $urandom_range(4095));
        end else begin
          send_req(brg_tb_pkg::ACT_BOUNDED, 32'hFFFF_F000 | $urandom_range(4095));
        end
      end
    end

    // Drop the request channel, drain and let the block settle
    in_valid       <= 1'b0;
    recv_stall_pct <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d raw and %0d bounded requests (%0d with bound below two)",
             raw_sent, bounded_sent, tiny_sent);
    $display("Loaded %0d seeds, compared %0d results over four pressure phases",
             seeds_loaded, compared);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/brg_pkg.sv
hdl/brg_mul.sv
hdl/brg_div.sv
hdl/bounded_random_generator_top.sv
dv/brg_tb_pkg.sv
dv/brg_checker.sv
dv/tb_bounded_random_generator_top.sv
